// ----- design/rtp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and helpers for the transform and projection core
// Holds the status codes, the sideband records that ride along the divider
// chains and the saturation helper used at the end of each divide.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Number of quotient bits produced by each divider chain.
  localparam int QBITS = 32;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_W_ZERO = 2'd1,
    ST_Z_ZERO = 2'd2
  } status_t;

  // Sideband carried through the camera-point divider.
  typedef struct packed {
    logic [2:0] over;
    logic [2:0] neg;
    logic       wneg;
    logic       wzero;
  } cam_side_t;

  // Sideband carried through the image-point divider.
  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
    status_t     status;
    logic [1:0]  cneg;
    logic        zneg;
    logic [1:0]  over;
  } img_side_t;

  // Apply the sign to a truncated quotient and clamp it to 32 signed bits.
  // An overflowed quotient counts as nonzero and always clamps.
  function automatic logic [31:0] sat32(input logic neg_in, input logic over,
                                        input logic [31:0] q);
    logic neg;
    neg = neg_in & (over | (q != 32'd0));
    if (over) begin
      sat32 = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg) begin
      sat32 = q[31] ? 32'h8000_0000 : (~q + 32'd1);
    end else begin
      sat32 = q[31] ? 32'h7FFF_FFFF : q;
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/rtp_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_div_cell: one restoring-division step
// Shifts one numerator bit into each lane's partial remainder, subtracts the
// divisor when it fits and appends the quotient bit, then hands the item on.
// ----------------------------------------------------------------------------
module rtp_div_cell
  import rtp_pkg::*;
#(
  parameter int W  = 64,
  parameter int L  = 3,
  parameter int SW = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [W-1:0]                  in_d,
  input  wire logic [L-1:0][W-1:0]           in_rem,
  input  wire logic [L-1:0][QBITS-1:0]       in_num,
  input  wire logic [L-1:0][QBITS-1:0]       in_q,
  input  wire logic [SW-1:0]                 in_side,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [W-1:0]                       out_d,
  output logic [L-1:0][W-1:0]                out_rem,
  output logic [L-1:0][QBITS-1:0]            out_num,
  output logic [L-1:0][QBITS-1:0]            out_q,
  output logic [SW-1:0]                      out_side
);

  logic [L-1:0][W-1:0]     rem_next;
  logic [L-1:0][QBITS-1:0] q_next;
  logic [L-1:0][QBITS-1:0] num_next;

  assign in_ready = !out_valid || out_ready;

  // Compare-subtract on each lane.
  always_comb begin
    logic [W:0] r2;
    logic       ge;
    for (int i = 0; i < L; i++) begin
      r2          = {in_rem[i], in_num[i][QBITS-1]};
      ge          = (r2 >= {1'b0, in_d});
      rem_next[i] = ge ? W'(r2 - {1'b0, in_d}) : r2[W-1:0];
      q_next[i]   = {in_q[i][QBITS-2:0], ge};
      num_next[i] = {in_num[i][QBITS-2:0], 1'b0};
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_d    <= in_d;
      out_rem  <= rem_next;
      out_num  <= num_next;
      out_q    <= q_next;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

// ----- design/rtp_div_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_div_chain: row of division cells
// Produces one quotient bit per cell, most significant first, so a full 32-bit
// quotient leaves the last cell; items enter every cycle unless stalled.
// ----------------------------------------------------------------------------
module rtp_div_chain
  import rtp_pkg::*;
#(
  parameter int W  = 64,
  parameter int L  = 3,
  parameter int SW = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [W-1:0]                  in_d,
  input  wire logic [L-1:0][W-1:0]           in_rem,
  input  wire logic [L-1:0][QBITS-1:0]       in_num,
  input  wire logic [SW-1:0]                 in_side,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [L-1:0][QBITS-1:0]            out_q,
  output logic [SW-1:0]                      out_side
);

  logic [QBITS:0]                          v;
  logic [QBITS:0]                          rdy;
  logic [QBITS:0][W-1:0]                   d;
  logic [QBITS:0][L-1:0][W-1:0]            rem;
  logic [QBITS:0][L-1:0][QBITS-1:0]        num;
  logic [QBITS:0][L-1:0][QBITS-1:0]        q;
  logic [QBITS:0][SW-1:0]                  side;

  assign v[0]     = in_valid;
  assign in_ready = rdy[0];
  assign d[0]     = in_d;
  assign rem[0]   = in_rem;
  assign num[0]   = in_num;
  assign q[0]     = '0;
  assign side[0]  = in_side;

  // One cell per quotient bit.
  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    rtp_div_cell #(.W(W), .L(L), .SW(SW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (rdy[k]),
      .in_d      (d[k]),
      .in_rem    (rem[k]),
      .in_num    (num[k]),
      .in_q      (q[k]),
      .in_side   (side[k]),
      .out_valid (v[k+1]),
      .out_ready (rdy[k+1]),
      .out_d     (d[k+1]),
      .out_rem   (rem[k+1]),
      .out_num   (num[k+1]),
      .out_q     (q[k+1]),
      .out_side  (side[k+1])
    );
  end

  assign out_valid  = v[QBITS];
  assign rdy[QBITS] = out_ready;
  assign out_q      = q[QBITS];
  assign out_side   = side[QBITS];

endmodule
`default_nettype wire

// ----- design/rigid_transform_and_project_core.sv -----
`default_nettype none
// Pipeline: an accepted item passes 3 transform stages, 32 camera divider cells,
// 1 saturation stage, 32 image divider cells and 1 output register to its result.
// Throughput: one item per cycle while the output is not stalled; every stage
// holds its own item, so the input is taken whenever any stage ahead has room.
// Reset: synchronous; empties the pipeline and loads the identity pose.
// ----------------------------------------------------------------------------
// rigid_transform_and_project_core: pose transform and perspective divide
// Multiplies (x, y, z, 1) by a 4x4 pose, divides by w, then divides x and y
// by z, with truncation and signed 32-bit saturation throughout.
// ----------------------------------------------------------------------------
module rigid_transform_and_project_core
  import rtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] obj_x,
  input  wire logic [31:0] obj_y,
  input  wire logic [31:0] obj_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      cam_x,
  output logic [31:0]      cam_y,
  output logic [31:0]      cam_z,
  output logic [31:0]      img_x,
  output logic [31:0]      img_y,
  output logic             behind_camera,
  output logic [1:0]       status
);

  localparam int CSW = $bits(cam_side_t);
  localparam int ISW = $bits(img_side_t);

  logic [63:0] pose [8];

  // Pose registers; a write lands on one row half.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        pose[i] <= '0;
      end
      pose[0] <= 64'd1 << (32 + FRAC_BITS);
      pose[2] <= 64'd1 << FRAC_BITS;
      pose[5] <= 64'd1 << (32 + FRAC_BITS);
      pose[7] <= 64'd1 << FRAC_BITS;
    end else if (cfg_we) begin
      pose[cfg_addr] <= cfg_wdata;
    end
  end

  // ---------------- Stage 0: products ----------------
  logic                     s0_v, s0_rdy;
  logic signed [63:0]       prod_n [4][4];
  logic signed [63:0]       s0_prod [4][4];
  logic                     s1_rdy;

  always_comb begin
    logic signed [31:0] m;
    logic signed [31:0] p;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m = c[0] ? pose[3'(r * 2 + c / 2)][31:0] : pose[3'(r * 2 + c / 2)][63:32];
        case (c)
          0:       p = obj_x;
          1:       p = obj_y;
          default: p = obj_z;
        endcase
        if (c == 3) begin
          prod_n[r][c] = 64'(m) <<< FRAC_BITS;
        end else begin
          prod_n[r][c] = m * p;
        end
      end
    end
  end

  assign s0_rdy   = !s0_v || s1_rdy;
  assign in_ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_rdy) begin
      s0_prod <= prod_n;
    end
  end

  // ---------------- Stage 1: row sums and magnitudes ----------------
  logic        s1_v;
  logic [63:0] mag_n [4];
  logic [3:0]  neg_n;
  logic [63:0] s1_mag [4];
  logic [3:0]  s1_neg;
  logic        s2_rdy;

  always_comb begin
    logic signed [65:0] h;
    for (int r = 0; r < 4; r++) begin
      h = 66'(s0_prod[r][0]) + 66'(s0_prod[r][1]) + 66'(s0_prod[r][2])
        + 66'(s0_prod[r][3]);
      neg_n[r] = h[65];
      mag_n[r] = h[65] ? (~h[63:0] + 64'd1) : h[63:0];
    end
  end

  assign s1_rdy = !s1_v || s2_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_v && s1_rdy) begin
      s1_mag <= mag_n;
      s1_neg <= neg_n;
    end
  end

  // ---------------- Stage 2: divider setup for x, y, z over w ----------------
  logic                    s2_v;
  logic [2:0][63:0]        rem_n;
  logic [2:0][QBITS-1:0]   lo_n;
  cam_side_t               cside_n;
  logic [63:0]             s2_d;
  logic [2:0][63:0]        s2_rem;
  logic [2:0][QBITS-1:0]   s2_lo;
  cam_side_t               s2_side;
  logic                    a_rdy;

  always_comb begin
    logic [95:0] num;
    cside_n.wneg  = s1_neg[3];
    cside_n.wzero = (s1_mag[3] == 64'd0);
    for (int i = 0; i < 3; i++) begin
      num             = 96'(s1_mag[i]) << FRAC_BITS;
      rem_n[i]        = num[95:32];
      lo_n[i]         = num[31:0];
      cside_n.over[i] = (num[95:32] >= s1_mag[3]);
      cside_n.neg[i]  = s1_neg[i];
    end
  end

  assign s2_rdy = !s2_v || a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_rdy) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && s2_rdy) begin
      s2_d    <= s1_mag[3];
      s2_rem  <= rem_n;
      s2_lo   <= lo_n;
      s2_side <= cside_n;
    end
  end

  // ---------------- Camera point divider ----------------
  logic                  a_v;
  logic                  s3_rdy;
  logic [2:0][QBITS-1:0] a_q;
  logic [CSW-1:0]        a_side_raw;
  cam_side_t             a_side;

  rtp_div_chain #(.W(64), .L(3), .SW(CSW)) u_cam_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_v),
    .in_ready  (a_rdy),
    .in_d      (s2_d),
    .in_rem    (s2_rem),
    .in_num    (s2_lo),
    .in_side   (s2_side),
    .out_valid (a_v),
    .out_ready (s3_rdy),
    .out_q     (a_q),
    .out_side  (a_side_raw)
  );

  assign a_side = cam_side_t'(a_side_raw);

  // ---------------- Stage 3: camera saturation, image divider setup ----------
  logic                  s3_v;
  img_side_t             iside_n;
  logic [1:0][31:0]      irem_n;
  logic [1:0][QBITS-1:0] ilo_n;
  logic [31:0]           zmag_n;
  img_side_t             s3_side;
  logic [1:0][31:0]      s3_rem;
  logic [1:0][QBITS-1:0] s3_lo;
  logic [31:0]           s3_d;
  logic                  b_rdy;

  always_comb begin
    logic [31:0] cam [3];
    logic [31:0] cmag;
    logic [63:0] num;
    for (int i = 0; i < 3; i++) begin
      cam[i] = a_side.wzero ? 32'd0
             : sat32(a_side.neg[i] ^ a_side.wneg, a_side.over[i], a_q[i]);
    end
    iside_n.cam_x = cam[0];
    iside_n.cam_y = cam[1];
    iside_n.cam_z = cam[2];
    if (a_side.wzero) begin
      iside_n.status = ST_W_ZERO;
    end else if (cam[2] == 32'd0) begin
      iside_n.status = ST_Z_ZERO;
    end else begin
      iside_n.status = ST_OK;
    end
    iside_n.zneg = cam[2][31];
    zmag_n       = cam[2][31] ? (~cam[2] + 32'd1) : cam[2];
    for (int i = 0; i < 2; i++) begin
      cmag             = cam[i][31] ? (~cam[i] + 32'd1) : cam[i];
      num              = 64'(cmag) << FRAC_BITS;
      irem_n[i]        = num[63:32];
      ilo_n[i]         = num[31:0];
      iside_n.cneg[i]  = cam[i][31];
      iside_n.over[i]  = (num[63:32] >= zmag_n);
    end
  end

  assign s3_rdy = !s3_v || b_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_rdy) begin
      s3_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v && s3_rdy) begin
      s3_side <= iside_n;
      s3_rem  <= irem_n;
      s3_lo   <= ilo_n;
      s3_d    <= zmag_n;
    end
  end

  // ---------------- Image point divider ----------------
  logic                  b_v;
  logic                  o_rdy;
  logic [1:0][QBITS-1:0] b_q;
  logic [ISW-1:0]        b_side_raw;
  img_side_t             b_side;

  rtp_div_chain #(.W(32), .L(2), .SW(ISW)) u_img_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_v),
    .in_ready  (b_rdy),
    .in_d      (s3_d),
    .in_rem    (s3_rem),
    .in_num    (s3_lo),
    .in_side   (s3_side),
    .out_valid (b_v),
    .out_ready (o_rdy),
    .out_q     (b_q),
    .out_side  (b_side_raw)
  );

  assign b_side = img_side_t'(b_side_raw);

  // ---------------- Output register ----------------
  logic [31:0] img_n [2];
  logic        ok;

  assign ok = (b_side.status == ST_OK);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      img_n[i] = ok ? sat32(b_side.cneg[i] ^ b_side.zneg, b_side.over[i], b_q[i])
                    : 32'd0;
    end
  end

  assign o_rdy = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_rdy) begin
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v && o_rdy) begin
      cam_x         <= b_side.cam_x;
      cam_y         <= b_side.cam_y;
      cam_z         <= b_side.cam_z;
      img_x         <= img_n[0];
      img_y         <= img_n[1];
      behind_camera <= ok & b_side.zneg;
      status        <= b_side.status;
    end
  end

`ifndef NO_ASSERTIONS
  // A zero w clears every result field.
  a_wzero_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_W_ZERO) |->
      (cam_x == 32'd0 && cam_y == 32'd0 && cam_z == 32'd0 && img_x == 32'd0
       && img_y == 32'd0 && !behind_camera))
    else $error("w-zero result carries nonzero fields");

  // A zero camera z gives zero image coordinates.
  a_zzero_img: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_Z_ZERO) |->
      (cam_z == 32'd0 && img_x == 32'd0 && img_y == 32'd0 && !behind_camera))
    else $error("z-zero result carries image fields");

  // The behind flag follows the sign of the camera z when the status is OK.
  a_behind_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (behind_camera == (cam_z[31] && status == ST_OK)))
    else $error("behind flag disagrees with camera z");
`endif

endmodule
`default_nettype wire

// ----- tb/rigid_transform_and_project_core_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_transform_and_project_core_test: self-checking bench for the core
// Loads a series of pose matrices and streams object points through the core with
// random gaps on both sides, plus one long output stall. Every result is checked
// per field against a bit-accurate transform and divide model or listed values.
// ----------------------------------------------------------------------------
module rigid_transform_and_project_core_test;
  import rtp_pkg::*;

  localparam int FRAC = 16;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int NUM_POSE_REGS = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int POINTS_PER_POSE = 190;

  // Pose register indexes.
  typedef enum logic [2:0] {
    R0_LEFT, R0_RIGHT, R1_LEFT, R1_RIGHT, R2_LEFT, R2_RIGHT, R3_LEFT, R3_RIGHT
  } pose_reg_t;

  // Kinds of pose loaded between phases.
  typedef enum int {
    POSE_NEAR_RIGID, POSE_RANDOM, POSE_EXTREME, POSE_W_ZERO, POSE_W_TILT, POSE_IDENTITY
  } pose_kind_t;

  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
    logic [31:0] img_x;
    logic [31:0] img_y;
    logic        behind;
    status_t     status;
  } point_result_t;

  typedef struct {
    logic [31:0]   x;
    logic [31:0]   y;
    logic [31:0]   z;
    logic          typed;
    point_result_t res;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] obj_x = '0, obj_y = '0, obj_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] cam_x, cam_y, cam_z, img_x, img_y;
  logic behind_camera;
  logic [1:0] status;

  logic [63:0] pose_regs [NUM_POSE_REGS];
  point_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int points_sent = 0;

  always #6 clk = ~clk;

  rigid_transform_and_project_core i_dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .obj_x, .obj_y, .obj_z,
    .out_valid, .out_ready, .cam_x, .cam_y, .cam_z, .img_x, .img_y,
    .behind_camera, .status
  );

  // Sign-apply and clamp a truncated quotient magnitude.
  function automatic logic [31:0] clamp_q(input logic neg, input logic [127:0] q);
    if (neg && q != 0) begin
      return (q >= 128'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // Transform a point by the current pose and project it.
  function automatic point_result_t project_point(input logic [31:0] px, py, pz);
    logic signed [127:0] pt [4];
    logic signed [127:0] h [4];
    logic signed [127:0] entry;
    logic signed [31:0] e32;
    logic [127:0] wmag, mag, q, zmag, cmag;
    logic wneg, zneg, cneg;
    logic [31:0] cam [3];
    point_result_t r;
    r = '0;
    pt[0] = $signed(px);
    pt[1] = $signed(py);
    pt[2] = $signed(pz);
    pt[3] = 128'sd1 <<< FRAC;
    for (int i = 0; i < 4; i++) begin
      h[i] = 0;
      for (int j = 0; j < 4; j++) begin
        e32 = j[0] ? pose_regs[i*2 + j/2][31:0] : pose_regs[i*2 + j/2][63:32];
        entry = e32;
        h[i] = h[i] + entry * pt[j];
      end
    end
    wneg = h[3] < 0;
    wmag = wneg ? -h[3] : h[3];
    if (wmag == 0) begin
      r.status = ST_W_ZERO;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      mag = (h[i] < 0) ? -h[i] : h[i];
      q = (mag << FRAC) / wmag;
      cam[i] = clamp_q((h[i] < 0) != wneg, q);
    end
    r.cam_x = cam[0];
    r.cam_y = cam[1];
    r.cam_z = cam[2];
    if (cam[2] == 0) begin
      r.status = ST_Z_ZERO;
      return r;
    end
    zneg = cam[2][31];
    zmag = zneg ? 128'(-$signed({1'b1, cam[2]})) : 128'(cam[2]);
    r.behind = zneg;
    for (int i = 0; i < 2; i++) begin
      cneg = cam[i][31];
      cmag = cneg ? 128'(-$signed({1'b1, cam[i]})) : 128'(cam[i]);
      q = (cmag << FRAC) / zmag;
      if (i == 0) r.img_x = clamp_q(cneg != zneg, q);
      else r.img_y = clamp_q(cneg != zneg, q);
    end
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] rand_entry(input pose_kind_t kind);
    case (kind)
      POSE_EXTREME: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      POSE_RANDOM:  return $urandom();
      default:      return 32'($signed($urandom_range(0, 4 * ONE)) - $signed(2 * ONE));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h0;
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3:       return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // Write one pose register and mirror it in the model.
  task automatic write_pose(input pose_reg_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    pose_regs[idx] = value;
    @(posedge clk);
  endtask

  // Load a whole pose of the given kind; only called with the core idle.
  task automatic load_pose(input pose_kind_t kind);
    logic [63:0] v;
    for (int r = 0; r < NUM_POSE_REGS; r++) begin
      v = {rand_entry(kind), rand_entry(kind)};
      if (kind == POSE_IDENTITY) begin
        v = (r == 0 || r == 5) ? {ONE, 32'h0} : (r == 2 || r == 7) ? {32'h0, ONE} : '0;
      end else if (r == R3_LEFT) begin
        if (kind == POSE_NEAR_RIGID || kind == POSE_W_ZERO) v = '0;
        if (kind == POSE_W_TILT) v = {32'h0, 32'h0000_0100};
      end else if (r == R3_RIGHT) begin
        if (kind == POSE_NEAR_RIGID || kind == POSE_W_TILT) v = {32'h0, ONE};
        if (kind == POSE_W_ZERO) v = '0;
      end
      write_pose(pose_reg_t'(r), v);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one point after a random gap and hold it until accepted.
  task automatic send_point(input point_row_t row);
    int gap;
    gap = ((points_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    obj_x <= row.x;
    obj_y <= row.y;
    obj_z <= row.z;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(row.typed ? row.res : project_point(row.x, row.y, row.z));
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed points under the reset pose, then random phases.
  initial begin
    point_row_t rows [$];
    point_row_t row;
    pose_kind_t kinds [6];
    kinds = '{POSE_NEAR_RIGID, POSE_W_TILT, POSE_RANDOM, POSE_EXTREME, POSE_W_ZERO,
              POSE_IDENTITY};
    pose_regs = '{{ONE, 32'h0}, 64'h0, {32'h0, ONE}, 64'h0, 64'h0, {ONE, 32'h0}, 64'h0,
                  {32'h0, ONE}};
    rows = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, ST_Z_ZERO}},
      '{ONE, 2*ONE, ONE, 1'b1, '{ONE, 2*ONE, ONE, ONE, 2*ONE, 1'b0, ST_OK}},
      '{-ONE, ONE, -ONE, 1'b1, '{-ONE, ONE, -ONE, ONE, -ONE, 1'b1, ST_OK}},
      '{32'h7FFF_FFFF, 32'h8000_0000, ONE, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, ONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, ST_OK}},
      '{ONE, -ONE, 32'h1, 1'b1,
        '{ONE, -ONE, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, ST_OK}},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'h1, 32'h1, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, '0},
      '{5*ONE, -3*ONE, 2*ONE, 1'b0, '0},
      '{32'h0, 32'h0, ONE, 1'b0, '0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_point(rows[i]);
    foreach (kinds[k]) begin
      wait_idle();
      load_pose(kinds[k]);
      for (int n = 0; n < POINTS_PER_POSE; n++) begin
        row.x = rand_coord();
        row.y = rand_coord();
        row.z = rand_coord();
        row.typed = 1'b0;
        row.res = '0;
        send_point(row);
      end
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stalls per item and one long hold-off to back up the pipe.
  // The hold-off starts early in a phase, so enough items remain to fill the core.
  initial begin
    int stall;
    logic held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && results_seen >= 210) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      stall = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each delivered item with the oldest expectation.
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (cam_x !== want.cam_x) begin
          $error("cam_x expected %h actual %h", want.cam_x, cam_x);
          mismatches++;
        end
        if (cam_y !== want.cam_y) begin
          $error("cam_y expected %h actual %h", want.cam_y, cam_y);
          mismatches++;
        end
        if (cam_z !== want.cam_z) begin
          $error("cam_z expected %h actual %h", want.cam_z, cam_z);
          mismatches++;
        end
        if (img_x !== want.img_x) begin
          $error("img_x expected %h actual %h", want.img_x, img_x);
          mismatches++;
        end
        if (img_y !== want.img_y) begin
          $error("img_y expected %h actual %h", want.img_y, img_y);
          mismatches++;
        end
        if (behind_camera !== want.behind) begin
          $error("behind_camera expected %b actual %b", want.behind, behind_camera);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #4800000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
